[design/hhq_pkg.sv]
package hhq_pkg;

    // Grid storage side, default for the top level parameter
    localparam int MAX_SIDE_DEF = 256;

    // Field widths
    localparam int SIZE_W     = 9;
    localparam int SCALE_W    = 24;
    localparam int IDX_W      = 8;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 24;
    localparam int HEIGHT_W   = 24;
    localparam int FRAC_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Sample value that stands for full height
    localparam int FULL_SCALE = 2 ** SAMPLE_W - 1;

    // Result buffer depth (power of two)
    localparam int OUT_DEPTH = 8;

    // Item action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH   = 2'd0,
        CFG_GRID_DEPTH   = 2'd1,
        CFG_INV_SCALE    = 2'd2,
        CFG_HEIGHT_SCALE = 2'd3
    } t_cfg_idx;

    // Register values after reset
    localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST   = 9'd256;
    localparam logic [SIZE_W-1:0]  GRID_DEPTH_RST   = 9'd256;
    localparam logic [SCALE_W-1:0] INV_SCALE_RST    = 24'd65536;
    localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 24'd256;

    // Query context handed from the read sequencer to the interpolator
    typedef struct packed {
        logic              hit;
        logic              upper;
        logic [FRAC_W-1:0] fu;
        logic [FRAC_W-1:0] fv;
    } t_meta;

endpackage

[design/hhq_intf.sv]
interface hhq_item_if import hhq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [IDX_W-1:0]           col;
    logic [IDX_W-1:0]           row;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [POS_W-1:0]    query_x;
    logic signed [POS_W-1:0]    query_z;

    modport source (output valid, action, col, row, sample, query_x, query_z, input ready);
    modport sink (input valid, action, col, row, sample, query_x, query_z, output ready);
endinterface

interface hhq_result_if import hhq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic                hit;

    modport source (output valid, height, hit, input ready);
    modport sink (input valid, height, hit, output ready);
endinterface

interface hhq_cfg_if import hhq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/hhq_ram.sv]
module hhq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/hhq_interp.sv]
module hhq_interp import hhq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_meta               i_meta,
    input  logic [SAMPLE_W-1:0] i_corner_a,
    input  logic [SAMPLE_W-1:0] i_corner_b,
    input  logic [SAMPLE_W-1:0] i_corner_c,
    input  logic [SCALE_W-1:0]  i_height_scale,
    output logic                o_valid,
    output logic [HEIGHT_W-1:0] o_height,
    output logic                o_hit
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int ACC_W  = SAMPLE_W + FRAC_W;
    localparam int HALF_W = ACC_W / 2;
    localparam int PART_W = HALF_W + SCALE_W;
    localparam int FULL_W = ACC_W + SCALE_W;
    localparam int Y_W    = FULL_W - FRAC_W;
    localparam int QUO_W  = Y_W - SAMPLE_W + 1;
    localparam logic [FULL_W-1:0] ROUND_BIAS = FULL_W'(FULL_SCALE) << (FRAC_W - 1);

    // Stage 1: edge differences
    logic                     r1_valid, r1_hit;
    logic [SAMPLE_W-1:0]      r1_a;
    logic signed [DIFF_W-1:0] r1_du, r1_dv, n_du, n_dv;
    logic [FRAC_W-1:0]        r1_fu, r1_fv;
    // Stage 2: weighted differences
    logic                     r2_valid, r2_hit;
    logic [SAMPLE_W-1:0]      r2_a;
    logic signed [PROD_W-1:0] r2_pu, r2_pv;
    // Stage 3: interpolated sample, Q16.24
    logic                     r3_valid, r3_hit;
    logic [ACC_W-1:0]         r3_acc;
    logic signed [PROD_W:0]   n_sum;
    // Stage 4: partial products of the height scaling
    logic                     r4_valid, r4_hit;
    logic [PART_W-1:0]        r4_phi, r4_plo;
    // Stage 5: product plus rounding bias, over 2^24
    logic                     r5_valid, r5_hit;
    logic [Y_W-1:0]           r5_y;
    logic [FULL_W-1:0]        n_full;
    // Stage 6: quotient estimate by 65535
    logic                     r6_valid, r6_hit;
    logic [Y_W-1:0]           r6_y;
    logic [QUO_W-1:0]         r6_e;
    logic [Y_W:0]             n_s;
    // Final correction
    logic [Y_W:0]             rem;
    logic [QUO_W:0]           quo;

    // Pick the triangle edges
    always_comb begin
        if (i_meta.upper) begin
            n_du = $signed({1'b0, i_corner_b}) - $signed({1'b0, i_corner_a});
            n_dv = $signed({1'b0, i_corner_c}) - $signed({1'b0, i_corner_b});
        end else begin
            n_du = $signed({1'b0, i_corner_c}) - $signed({1'b0, i_corner_b});
            n_dv = $signed({1'b0, i_corner_b}) - $signed({1'b0, i_corner_a});
        end
    end

    assign n_sum = $signed({1'b0, r2_a, {FRAC_W{1'b0}}}) + r2_pu + r2_pv;

    assign n_full = (FULL_W'(r4_phi) << HALF_W) + FULL_W'(r4_plo) + ROUND_BIAS;

    // Reciprocal series for 1/65535, never above the true quotient, at most one below
    assign n_s = (Y_W+1)'(r5_y) + (Y_W+1)'(r5_y >> SAMPLE_W) + (Y_W+1)'(r5_y >> (2 * SAMPLE_W));

    // Remainder check fixes the estimate
    assign rem = (Y_W+1)'(r6_y) + (Y_W+1)'(r6_e) - ((Y_W+1)'(r6_e) << SAMPLE_W);
    assign quo = (QUO_W+1)'(r6_e) + (QUO_W+1)'(rem >= (Y_W+1)'(FULL_SCALE));

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r1_hit <= i_meta.hit;
        r1_a   <= i_corner_a;
        r1_du  <= n_du;
        r1_dv  <= n_dv;
        r1_fu  <= i_meta.fu;
        r1_fv  <= i_meta.fv;

        r2_hit <= r1_hit;
        r2_a   <= r1_a;
        r2_pu  <= r1_du * $signed({1'b0, r1_fu});
        r2_pv  <= r1_dv * $signed({1'b0, r1_fv});

        r3_hit <= r2_hit;
        r3_acc <= n_sum[PROD_W] ? '0 : n_sum[ACC_W-1:0];

        r4_hit <= r3_hit;
        r4_phi <= r3_acc[ACC_W-1:HALF_W] * i_height_scale;
        r4_plo <= r3_acc[HALF_W-1:0] * i_height_scale;

        r5_hit <= r4_hit;
        r5_y   <= n_full[FULL_W-1:FRAC_W];

        r6_hit <= r5_hit;
        r6_y   <= r5_y;
        r6_e   <= n_s[Y_W:SAMPLE_W];
    end

    // Saturate, force zero on a miss
    always_comb begin
        if (!r6_hit) begin
            o_height = '0;
        end else if (quo[QUO_W:HEIGHT_W] != '0) begin
            o_height = '1;
        end else begin
            o_height = quo[HEIGHT_W-1:0];
        end
    end

    assign o_valid = r6_valid;
    assign o_hit   = r6_hit;

endmodule

[design/heightmap_height_query_unit.sv]
// Heightmap height query. Words on i_item either write one 16-bit sample into
// a MAX_SIDE x MAX_SIDE grid (row-major) or query the height at a local (x, z)
// position; each query gives exactly one word on o_result, writes give none.
// All samples sit in one single-port RAM with a registered read, so the port
// sets the rate: a write uses it once, a query that misses the grid reads
// nothing, and a query that lands in a cell reads its three triangle corners
// one after another. Input, coordinate and read stages overlap, so a new
// word can be taken while an earlier query is still reading its corners.
// A query waits in the coordinate stage for a free result credit. An
// 8-word result buffer sits behind the pipeline, and at most eight queries
// may be outstanding, so o_result stalls back up the input only once eight
// results are waiting or in flight. Writes and reads use the RAM port in
// arrival order, so a query always sees earlier writes. The grid is not
// cleared at reset; a query must only touch written samples.
// Configuration words are taken every cycle and must come while the block
// is idle.
module heightmap_height_query_unit import hhq_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hhq_cfg_if.sink      i_cfg,
    hhq_item_if.sink     i_item,
    hhq_result_if.source o_result
);

    localparam int CELL_W = $clog2(MAX_SIDE);
    localparam int GRID_N = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(GRID_N);
    localparam int SZ_W   = ($clog2(MAX_SIDE + 1) > SIZE_W) ? $clog2(MAX_SIDE + 1) : SIZE_W;
    localparam int T_W    = POS_W + SCALE_W + 1;
    localparam int CI_W   = T_W - FRAC_W;
    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int PTR_W  = $clog2(OUT_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_B,
        S_RD_C
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] row,
                                                    input logic [CELL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
    endfunction

    // Configuration registers
    logic [SIZE_W-1:0]  r_grid_width, r_grid_depth;
    logic [SCALE_W-1:0] r_inv_scale, r_height_scale;
    logic               cfg_fire;
    logic [SZ_W-1:0]    eff_w, eff_d;
    logic signed [T_W-1:0] half_w, half_d;

    // Input stage
    logic                    r_p0_valid, r_p0_action;
    logic [IDX_W-1:0]        r_p0_col, r_p0_row;
    logic [SAMPLE_W-1:0]     r_p0_sample;
    logic signed [POS_W-1:0] r_p0_qx, r_p0_qz;
    logic                    item_fire;

    // Coordinate stage
    logic                  r_p1_valid, r_p1_action, r_p1_wok;
    logic [ADDR_W-1:0]     r_p1_waddr;
    logic [SAMPLE_W-1:0]   r_p1_sample;
    logic signed [T_W-1:0] r_p1_tx, r_p1_tz, n_tx, n_tz;
    logic                  p1_load, p1_done;

    // Read sequencer
    t_state              r_state, n_state;
    logic                hit_x, hit_z, q_hit, upper;
    logic [CELL_W-1:0]   u0, v0;
    logic [FRAC_W-1:0]   fu, fv;
    logic [ADDR_W-1:0]   addr_a, addr_b, addr_c;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                r_m_valid, n_m_valid;
    t_meta               r_meta, n_meta;
    logic [SAMPLE_W-1:0] r_corner_a, r_corner_b;
    logic                take, credit_ok;

    // Interpolator output and result buffer
    logic                res_valid, res_hit;
    logic [HEIGHT_W-1:0] res_height;
    logic [CNT_W-1:0]    r_credit, n_credit, r_count;
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [HEIGHT_W-1:0] r_fifo_height [OUT_DEPTH];
    logic                r_fifo_hit [OUT_DEPTH];
    logic                pop;

    // Write configuration
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= GRID_WIDTH_RST;
            r_grid_depth   <= GRID_DEPTH_RST;
            r_inv_scale    <= INV_SCALE_RST;
            r_height_scale <= HEIGHT_SCALE_RST;
        end else if (cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_GRID_WIDTH:   r_grid_width   <= i_cfg.data[SIZE_W-1:0];
                CFG_GRID_DEPTH:   r_grid_depth   <= i_cfg.data[SIZE_W-1:0];
                CFG_INV_SCALE:    r_inv_scale    <= i_cfg.data[SCALE_W-1:0];
                CFG_HEIGHT_SCALE: r_height_scale <= i_cfg.data[SCALE_W-1:0];
            endcase
        end
    end

    // Clamp grid sizes to storage, form half spans
    assign eff_w = (SZ_W'(r_grid_width) > SZ_W'(MAX_SIDE)) ? SZ_W'(MAX_SIDE)
                                                          : SZ_W'(r_grid_width);
    assign eff_d = (SZ_W'(r_grid_depth) > SZ_W'(MAX_SIDE)) ? SZ_W'(MAX_SIDE)
                                                          : SZ_W'(r_grid_depth);
    assign half_w = $signed(T_W'({eff_w - SZ_W'(1), {(FRAC_W - 1){1'b0}}}));
    assign half_d = $signed(T_W'({eff_d - SZ_W'(1), {(FRAC_W - 1){1'b0}}}));

    // Input stage: hold a word until the coordinate stage takes it
    assign p1_load      = r_p0_valid && (!r_p1_valid || p1_done);
    assign i_item.ready = !r_p0_valid || p1_load;
    assign item_fire    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (item_fire) begin
            r_p0_valid <= 1'b1;
        end else if (p1_load) begin
            r_p0_valid <= 1'b0;
        end
        if (item_fire) begin
            r_p0_action <= i_item.action;
            r_p0_col    <= i_item.col;
            r_p0_row    <= i_item.row;
            r_p0_sample <= i_item.sample;
            r_p0_qx     <= i_item.query_x;
            r_p0_qz     <= i_item.query_z;
        end
    end

    // Coordinate stage: cell coordinates in Q.24
    assign n_tx = r_p0_qx * $signed({1'b0, r_inv_scale}) + half_w;
    assign n_tz = r_p0_qz * $signed({1'b0, r_inv_scale}) + half_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (p1_load) begin
            r_p1_valid <= 1'b1;
        end else if (p1_done) begin
            r_p1_valid <= 1'b0;
        end
        if (p1_load) begin
            r_p1_action <= r_p0_action;
            r_p1_sample <= r_p0_sample;
            r_p1_waddr  <= cell_addr(CELL_W'(r_p0_row), CELL_W'(r_p0_col));
            r_p1_wok    <= (32'(r_p0_col) < 32'(MAX_SIDE)) && (32'(r_p0_row) < 32'(MAX_SIDE));
            r_p1_tx     <= n_tx;
            r_p1_tz     <= n_tz;
        end
    end

    // Cell hit test and corner addresses
    assign hit_x = !r_p1_tx[T_W-1] && (eff_w >= SZ_W'(2))
                   && ({1'b0, r_p1_tx[T_W-2:FRAC_W]} < CI_W'(eff_w) - CI_W'(1));
    assign hit_z = !r_p1_tz[T_W-1] && (eff_d >= SZ_W'(2))
                   && ({1'b0, r_p1_tz[T_W-2:FRAC_W]} < CI_W'(eff_d) - CI_W'(1));
    assign q_hit = hit_x && hit_z;
    assign u0    = r_p1_tx[FRAC_W +: CELL_W];
    assign v0    = r_p1_tz[FRAC_W +: CELL_W];
    assign fu    = r_p1_tx[FRAC_W-1:0];
    assign fv    = r_p1_tz[FRAC_W-1:0];
    assign upper = fu > fv;

    assign addr_a = cell_addr(v0, u0);
    assign addr_b = upper ? addr_a + ADDR_W'(1) : addr_a + ADDR_W'(MAX_SIDE);
    assign addr_c = addr_a + ADDR_W'(MAX_SIDE) + ADDR_W'(1);

    assign credit_ok = r_credit < CNT_W'(OUT_DEPTH);

    // Sequence the RAM port: writes, then up to three corner reads per query
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = addr_a;
        p1_done   = 1'b0;
        take      = 1'b0;
        n_m_valid = 1'b0;
        n_meta    = '{hit: q_hit, upper: upper, fu: fu, fv: fv};
        unique case (r_state)
            S_IDLE: begin
                if (r_p1_valid) begin
                    case (r_p1_action)
                        ACT_WRITE: begin
                            ram_we   = r_p1_wok;
                            ram_addr = r_p1_waddr;
                            p1_done  = 1'b1;
                        end
                        ACT_QUERY: begin
                            if (credit_ok) begin
                                take = 1'b1;
                                if (q_hit) begin
                                    n_state = S_RD_B;
                                end else begin
                                    p1_done   = 1'b1;
                                    n_m_valid = 1'b1;
                                end
                            end
                        end
                        default: p1_done = 1'b0;
                    endcase
                end
            end
            S_RD_B: begin
                ram_addr = addr_b;
                n_state  = S_RD_C;
            end
            S_RD_C: begin
                ram_addr  = addr_c;
                p1_done   = 1'b1;
                n_m_valid = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, launch context, capture the first two corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
        r_meta <= n_meta;
        if (r_state == S_RD_B) begin
            r_corner_a <= ram_rdata;
        end
        if (r_state == S_RD_C) begin
            r_corner_b <= ram_rdata;
        end
    end

    hhq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (GRID_N)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_p1_sample),
        .o_rdata (ram_rdata)
    );

    // Third corner comes straight from the RAM
    hhq_interp u_interp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_m_valid),
        .i_meta         (r_meta),
        .i_corner_a     (r_corner_a),
        .i_corner_b     (r_corner_b),
        .i_corner_c     (ram_rdata),
        .i_height_scale (r_height_scale),
        .o_valid        (res_valid),
        .o_height       (res_height),
        .o_hit          (res_hit)
    );

    // Result buffer; credits keep it from overflowing
    assign pop      = o_result.valid && o_result.ready;
    assign n_credit = r_credit + CNT_W'(take) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_credit <= n_credit;
            r_count  <= r_count + CNT_W'(res_valid) - CNT_W'(pop);
            if (res_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
        if (res_valid) begin
            r_fifo_height[r_wr_ptr] <= res_height;
            r_fifo_hit[r_wr_ptr]    <= res_hit;
        end
    end

    assign o_result.valid  = (r_count != '0);
    assign o_result.height = r_fifo_height[r_rd_ptr];
    assign o_result.hit    = r_fifo_hit[r_rd_ptr];

    // Credits cover the buffer
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CNT_W'(OUT_DEPTH))
        else $error("result credits exceed buffer depth");

    a_count_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_credit)
        else $error("buffered results exceed issued queries");

    a_launch_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_C) |=> r_m_valid)
        else $error("corner reads finished without launching interpolation");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE && r_p1_valid && r_p1_action == ACT_WRITE))
        else $error("grid write outside an accepted write word");

    a_read_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_p1_valid)
        else $error("corner read without a held query");

endmodule

[bench/tb_heightmap_height_query_unit.sv]
module tb_heightmap_height_query_unit;
    import hhq_pkg::*;

    localparam int GRID_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_GAP = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 170;

    // One word on the item channel
    typedef struct {
        logic                       action;
        logic [IDX_W-1:0]           col;
        logic [IDX_W-1:0]           row;
        logic [SAMPLE_W-1:0]        sample;
        logic signed [POS_W-1:0]    query_x;
        logic signed [POS_W-1:0]    query_z;
    } t_grid_word;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic                hit;
    } t_height_result;

    // Tracks the grid and registers, predicts each query and checks results
    class height_scoreboard;
        logic [SAMPLE_W-1:0] grid_mem [GRID_CELLS];
        bit                  written [GRID_CELLS];
        logic [SIZE_W-1:0]   grid_width;
        logic [SIZE_W-1:0]   grid_depth;
        logic [SCALE_W-1:0]  inv_scale;
        logic [SCALE_W-1:0]  height_scale;
        t_height_result      pending_heights [$];
        int                  mismatches;
        int                  n_writes;
        int                  n_queries;
        int                  n_hits;

        function new();
            grid_width   = GRID_WIDTH_RST;
            grid_depth   = GRID_DEPTH_RST;
            inv_scale    = INV_SCALE_RST;
            height_scale = HEIGHT_SCALE_RST;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_WIDTH:   grid_width = data[SIZE_W-1:0];
                CFG_GRID_DEPTH:   grid_depth = data[SIZE_W-1:0];
                CFG_INV_SCALE:    inv_scale = data[SCALE_W-1:0];
                CFG_HEIGHT_SCALE: height_scale = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp an oversized grid to the storage side
        function int unsigned span(logic [SIZE_W-1:0] n);
            return (n > MAX_SIDE_DEF) ? MAX_SIDE_DEF : n;
        endfunction

        // Map one coordinate onto a cell index and Q0.24 fraction
        function bit map_axis(logic signed [POS_W-1:0] pos, int unsigned size,
                              output int unsigned cell_idx, output longint frac);
            longint t;
            cell_idx = 0;
            frac = 0;
            if (size < 2)
                return 0;
            t = longint'(pos) * longint'({1'b0, inv_scale}) + (longint'(size - 1) <<< 23);
            if (t < 0)
                return 0;
            if ((t >>> 24) + 1 >= size)
                return 0;
            cell_idx = 32'(t >>> 24);
            frac = t & longint'(24'hFFFFFF);
            return 1;
        endfunction

        function bit locate(logic signed [POS_W-1:0] qx, logic signed [POS_W-1:0] qz,
                            output int unsigned u0, output int unsigned v0,
                            output longint fu, output longint fv);
            bit hit_x;
            bit hit_z;
            hit_x = map_axis(qx, span(grid_width), u0, fu);
            hit_z = map_axis(qz, span(grid_depth), v0, fv);
            return hit_x && hit_z;
        endfunction

        // Interpolate over the chosen triangle, then scale and round
        function t_height_result predict_height(logic signed [POS_W-1:0] qx,
                                                logic signed [POS_W-1:0] qz);
            t_height_result res;
            int unsigned    u0, v0;
            longint         fu, fv, p00, p10, p01, p11, du, dv, acc;
            logic [95:0]    prod, den, h;
            res.height = '0;
            res.hit = 1'b0;
            if (!locate(qx, qz, u0, v0, fu, fv))
                return res;
            p00 = grid_mem[v0 * MAX_SIDE_DEF + u0];
            p10 = grid_mem[v0 * MAX_SIDE_DEF + u0 + 1];
            p01 = grid_mem[(v0 + 1) * MAX_SIDE_DEF + u0];
            p11 = grid_mem[(v0 + 1) * MAX_SIDE_DEF + u0 + 1];
            if (fu > fv) begin
                du = p10 - p00;
                dv = p11 - p10;
            end else begin
                du = p11 - p01;
                dv = p01 - p00;
            end
            acc = (p00 <<< 24) + du * fu + dv * fv;
            if (acc < 0)
                acc = 0;
            prod = 96'(acc) * 96'(height_scale);
            den = 96'(FULL_SCALE) << 24;
            h = (prod + den / 2) / den;
            if (h > 96'(24'hFFFFFF))
                h = 96'(24'hFFFFFF);
            res.height = h[HEIGHT_W-1:0];
            res.hit = 1'b1;
            return res;
        endfunction

        // Note an accepted item word: store a sample or queue a prediction
        function void take_item(t_grid_word w);
            t_height_result res;
            if (w.action == ACT_WRITE) begin
                grid_mem[int'(w.row) * MAX_SIDE_DEF + int'(w.col)] = w.sample;
                written[int'(w.row) * MAX_SIDE_DEF + int'(w.col)] = 1'b1;
                n_writes++;
            end else begin
                res = predict_height(w.query_x, w.query_z);
                pending_heights = {pending_heights, res};
                n_queries++;
                if (res.hit)
                    n_hits++;
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_result(logic [HEIGHT_W-1:0] height, logic hit);
            t_height_result exp_res;
            if (pending_heights.size() == 0) begin
                report($sformatf("unexpected result: height=%0d hit=%0b", height, hit));
                return;
            end
            exp_res = pending_heights.pop_front();
            if (hit !== exp_res.hit)
                report($sformatf("hit mismatch: expected %0b, got %0b", exp_res.hit, hit));
            if (height !== exp_res.height)
                report($sformatf("height mismatch: expected %0d, got %0d",
                                 exp_res.height, height));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hhq_cfg_if    cfg_bus ();
    hhq_item_if   item_bus ();
    hhq_result_if result_bus ();

    heightmap_height_query_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    height_scoreboard sb = new();

    int send_pct;
    int stall_pct;
    int hold_req;
    int hold_left;
    int n_settings;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // End the run if the block hangs
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Accept result words, stall at random, and hold off on request
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.height, result_bus.hit);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item word after a random gap and wait for its handshake
    task automatic send_word(t_grid_word w);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.action  <= w.action;
        item_bus.col     <= w.col;
        item_bus.row     <= w.row;
        item_bus.sample  <= w.sample;
        item_bus.query_x <= w.query_x;
        item_bus.query_z <= w.query_z;
        item_bus.valid   <= 1'b1;
        do @(posedge i_clk); while (!item_bus.ready);
        sb.take_item(w);
    endtask

    task automatic send_write(int unsigned col, int unsigned row, int unsigned sample);
        t_grid_word w;
        w.action  = ACT_WRITE;
        w.col     = col[IDX_W-1:0];
        w.row     = row[IDX_W-1:0];
        w.sample  = SAMPLE_W'(sample);
        w.query_x = POS_W'($urandom);
        w.query_z = POS_W'($urandom);
        send_word(w);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return SAMPLE_W'(FULL_SCALE);
        return SAMPLE_W'($urandom);
    endfunction

    // Write any corner of the target cell not yet written, then query it
    task automatic send_query(int qx, int qz);
        t_grid_word  w;
        int unsigned u0, v0;
        longint      fu, fv;
        w.query_x = POS_W'(qx);
        w.query_z = POS_W'(qz);
        if (sb.locate(w.query_x, w.query_z, u0, v0, fu, fv)) begin
            for (int dz = 0; dz < 2; dz++)
                for (int dx = 0; dx < 2; dx++)
                    if (!sb.written[(v0 + dz) * MAX_SIDE_DEF + u0 + dx])
                        send_write(u0 + dx, v0 + dz, random_sample());
        end
        w.action  = ACT_QUERY;
        w.col     = IDX_W'($urandom);
        w.row     = IDX_W'($urandom);
        w.sample  = SAMPLE_W'($urandom);
        send_word(w);
    endtask

    // Position that mostly lands in or near the grid under the current spacing
    function automatic logic signed [POS_W-1:0] random_pos(int unsigned size);
        longint      lim, r;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return POS_W'($urandom);
        if (sb.inv_scale == 0)
            lim = 8388607;
        else
            lim = ((longint'(size) / 2 + 2) <<< 24) / longint'({1'b0, sb.inv_scale});
        if (lim > 8388607)
            lim = 8388607;
        if (sel >= 55)
            lim = lim / 8 + 1;
        r = longint'($urandom_range(32'(2 * lim))) - lim;
        return r[POS_W-1:0];
    endfunction

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_drain();
        item_bus.valid <= 1'b0;
        while (sb.pending_heights.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(int unsigned w, int unsigned d,
                                int unsigned inv, int unsigned hs);
        logic [CFG_DATA_W-1:0] vals [4];
        t_cfg_idx              idx;
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(d), CFG_DATA_W'(inv), CFG_DATA_W'(hs)};
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            cfg_bus.index <= idx;
            cfg_bus.data  <= vals[i];
            cfg_bus.valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_bus.ready);
            sb.set_reg(idx, vals[i]);
        end
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    // One register setting followed by a stream of random writes and queries
    task automatic run_phase(int unsigned w, int unsigned d,
                             int unsigned inv, int unsigned hs,
                             int idle_pct, int busy_pct, int hold_at, int pause_at);
        int          start;
        int          sent;
        int unsigned cols, rows;
        wait_drain();
        program_regs(w, d, inv, hs);
        send_pct = idle_pct;
        stall_pct = busy_pct;
        start = sb.n_writes + sb.n_queries;
        sent = 0;
        cols = sb.span(sb.grid_width);
        rows = sb.span(sb.grid_depth);
        while (sent < PHASE_WORDS) begin
            if (sent >= hold_at && hold_at >= 0) begin
                hold_req = HOLD_CYCLES;
                hold_at = -1;
            end
            if (sent >= pause_at && pause_at >= 0) begin
                wait_drain();
                pause_at = -1;
            end
            if ($urandom_range(99) < 65)
                send_query(random_pos(cols), random_pos(rows));
            else if ($urandom_range(1) == 0 && cols > 0 && rows > 0)
                send_write($urandom_range(cols - 1), $urandom_range(rows - 1),
                           random_sample());
            else
                send_write($urandom, $urandom, random_sample());
            sent = sb.n_writes + sb.n_queries - start;
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_GRID_WIDTH;
        cfg_bus.data = '0;
        item_bus.valid = 1'b0;
        item_bus.action = ACT_WRITE;
        item_bus.col = '0;
        item_bus.row = '0;
        item_bus.sample = '0;
        item_bus.query_x = '0;
        item_bus.query_z = '0;
        result_bus.ready = 1'b0;
        send_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        n_settings = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset register values: grid corners,
        // sample extremes, both triangles, cell edges and far misses
        send_write(0, 0, 0);
        send_write(255, 255, FULL_SCALE);
        send_write(0, 255, FULL_SCALE);
        send_write(255, 0, 0);
        send_write(127, 127, 0);
        send_write(128, 127, FULL_SCALE);
        send_write(127, 128, 1234);
        send_write(128, 128, 40000);
        send_query(0, 0);
        send_query(64, 0);
        send_query(0, 64);
        send_query(-8388608, 8388607);
        send_query(8388607, 0);
        send_query(-32640, -32640);
        send_query(-32641, 0);
        send_query(32384, 32384);
        send_query(32640, 0);
        send_query(0, -32641);

        // Register settings, extremes first, each with its own idling mix
        run_phase(2, 2, 65536, 24'hFFFFFF, 0, 0, 40, -1);
        run_phase(256, 256, 24'hFFFFFF, 0, 85, 0, -1, -1);
        run_phase(9, 5, 0, 123456, 0, 85, -1, -1);
        run_phase(511, 300, 40000, 256, 26, 26, -1, -1);
        run_phase(0, 1, $urandom, $urandom, 0, 0, -1, -1);
        run_phase(16, 16, 300000, 5000000, 85, 0, -1, 90);
        run_phase(257, 3, 1, 24'hFFFFFF, 0, 85, -1, -1);
        run_phase(64, 200, 196608, 700, 26, 26, -1, -1);
        run_phase($urandom_range(2, 40), $urandom_range(2, 40), $urandom_range(1, 2000000),
                  $urandom, 0, 0, -1, -1);
        wait_drain();

        $display("Covered %0d grid writes and %0d queries (%0d in grid) over %0d settings",
                 sb.n_writes, sb.n_queries, sb.n_hits, n_settings);
        $display("Result mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
design/hhq_pkg.sv
design/hhq_intf.sv
design/hhq_ram.sv
design/hhq_interp.sv
design/heightmap_height_query_unit.sv
bench/tb_heightmap_height_query_unit.sv
